### rtl/temp_band_fan_level_qualifier_core_macros.svh
// Assertion macros for the temp band fan level qualifier core.
// Included by the top level; needs nothing else.
`ifndef TEMP_BAND_FAN_LEVEL_QUALIFIER_CORE_MACROS_SVH
`define TEMP_BAND_FAN_LEVEL_QUALIFIER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TBFL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tbfl_pkg.sv
// Shared types and constants for the temp band fan level qualifier core.
// No dependencies.
package tbfl_pkg;

  localparam int TEMP_MUL    = 731;
  localparam int MUL_BITS    = 10;
  localparam int TEMP_SHIFT  = 14;
  localparam int TEMP_OFFSET = 273;
  localparam int NUM_LIMITS  = 5;
  localparam int BAND_W      = 3;
  localparam int CFG_IDX_W   = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BAND0_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND1_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND2_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND3_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND4_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUALIFY_COUNT = 3'd5;

  // reset values
  localparam logic [7:0] BAND0_LIMIT_RST   = 8'd38;
  localparam logic [7:0] BAND1_LIMIT_RST   = 8'd45;
  localparam logic [7:0] BAND2_LIMIT_RST   = 8'd46;
  localparam logic [7:0] BAND3_LIMIT_RST   = 8'd47;
  localparam logic [7:0] BAND4_LIMIT_RST   = 8'd48;
  localparam logic [7:0] QUALIFY_COUNT_RST = 8'd3;

  localparam logic [BAND_W-1:0] BAND_TOP = 3'd5;

  typedef struct packed {
    logic [NUM_LIMITS-1:0][7:0] limit;
    logic [7:0]                 qual_cnt;
  } cfg_t;

  typedef struct packed {
    logic [BAND_W-1:0] fan_level;
    logic signed [7:0] avg_temp;
    logic [BAND_W-1:0] sample_band;
  } res_t;

endpackage

### rtl/tbfl_conv.sv
// Raw sensor code to saturated signed degrees: floor(code*731/2^14) - 273.
// Uses tbfl_pkg constants.
module tbfl_conv #(
  parameter int SENSOR_BITS = 16
) (
  input  logic [15:0]       raw,
  output logic signed [7:0] deg
);

  localparam int PROD_W = SENSOR_BITS + tbfl_pkg::MUL_BITS;
  localparam int SCL_W  = PROD_W - tbfl_pkg::TEMP_SHIFT;
  localparam int DEG_W  = (SCL_W + 1 > 10) ? SCL_W + 1 : 10;
  localparam logic signed [DEG_W-1:0] SAT_HI = DEG_W'(127);
  localparam logic signed [DEG_W-1:0] SAT_LO = DEG_W'(-128);
  localparam logic signed [DEG_W-1:0] OFFSET = DEG_W'(tbfl_pkg::TEMP_OFFSET);

  logic [SENSOR_BITS-1:0]   code;
  logic [PROD_W-1:0]        prod;
  logic [SCL_W-1:0]         scaled;
  logic signed [DEG_W-1:0]  deg_full;

  assign code     = raw[SENSOR_BITS-1:0];
  assign prod     = PROD_W'(code) * PROD_W'(tbfl_pkg::TEMP_MUL);
  assign scaled   = prod[PROD_W-1:tbfl_pkg::TEMP_SHIFT];
  assign deg_full = $signed(DEG_W'(scaled)) - OFFSET;

  always_comb begin
    if (deg_full > SAT_HI) begin
      deg = 8'sd127;
    end else if (deg_full < SAT_LO) begin
      deg = -8'sd128;
    end else begin
      deg = deg_full[7:0];
    end
  end

endmodule

### rtl/tbfl_qual.sv
// Averaging, band lookup and run-length qualification of the fan level.
// Holds last band, run count and level; uses tbfl_pkg.
module tbfl_qual (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  logic signed [7:0]               temp_a,
  input  logic signed [7:0]               temp_b,
  input  tbfl_pkg::cfg_t                  cfg,
  output tbfl_pkg::res_t                  res,
  output logic [tbfl_pkg::BAND_W-1:0]     cur_level
);

  logic signed [8:0]               sum;
  logic signed [8:0]               sum_adj;
  logic signed [7:0]               avg;
  logic [tbfl_pkg::BAND_W-1:0]     band;
  logic [7:0]                      need;
  logic [7:0]                      run_inc;
  logic                            hit;

  logic [tbfl_pkg::BAND_W-1:0]     last_band_r, last_band_nxt;
  logic [7:0]                      run_count_r, run_count_nxt;
  logic [tbfl_pkg::BAND_W-1:0]     level_r, level_nxt;

  // halve rounding toward zero: bias negatives by one before the shift
  assign sum     = 9'(temp_a) + 9'(temp_b);
  assign sum_adj = sum + (sum[8] ? 9'sd1 : 9'sd0);
  assign avg     = 8'(sum_adj >>> 1);

  always_comb begin
    band = tbfl_pkg::BAND_TOP;
    for (int k = tbfl_pkg::NUM_LIMITS - 1; k >= 0; k--) begin
      if (avg <= $signed(cfg.limit[k])) begin
        band = tbfl_pkg::BAND_W'(k);
      end
    end
  end

  assign need    = (cfg.qual_cnt == 8'd0) ? 8'd1 : cfg.qual_cnt;
  assign run_inc = (band == last_band_r) ? run_count_r + 8'd1 : 8'd1;
  assign hit     = (run_inc == need);

  always_comb begin
    last_band_nxt = last_band_r;
    run_count_nxt = run_count_r;
    level_nxt     = level_r;
    if (advance) begin
      last_band_nxt = band;
      run_count_nxt = hit ? 8'd0 : run_inc;
      level_nxt     = hit ? band : level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_band_r <= '0;
      run_count_r <= '0;
      level_r     <= '0;
    end else begin
      last_band_r <= last_band_nxt;
      run_count_r <= run_count_nxt;
      level_r     <= level_nxt;
    end
  end

  assign res.fan_level   = hit ? band : level_r;
  assign res.avg_temp    = avg;
  assign res.sample_band = band;
  assign cur_level       = level_r;

endmodule

### rtl/temp_band_fan_level_qualifier_core.sv
// Top level of the temp band fan level qualifier core.
// Depends on tbfl_pkg, tbfl_conv, tbfl_qual and the macros header.
//
// Usage:
//   in_*  : stream of sensor words, two raw 16-bit codes per word.
//   out_* : one result word per input word, in order.
//   cfg_* : write port for the five band limits and the qualify count;
//           write only while the block is idle.
// Timing:
//   A word is captured in the input register when accepted and moves to
//   the result register once that register is empty or drained, which
//   raises out_tvalid. One word per cycle is sustained while out_tready
//   is high; conversion, averaging, band compare and qualifier update sit
//   in the single combinational stage between the two registers.
// Reset (rst_n low, synchronous): both stages empty, limits and qualify
//   count back to defaults, run count, last band and fan level zero.
// Stall: while out_tready is low the result holds; the input register
//   still takes one more word, then in_tready drops until the result
//   register drains.
`include "temp_band_fan_level_qualifier_core_macros.svh"

module temp_band_fan_level_qualifier_core #(
  parameter int SENSOR_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] raw_sensor_a, [31:16] raw_sensor_b
  input  logic [31:0]                      in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] fan_level, [10:3] avg_temp, [13:11] sample_band, [15:14] zero
  output logic [15:0]                      out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [tbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_wdata
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic [15:0]                   s1_a_r, s1_b_r;
  logic                          out_valid_r, out_valid_nxt;
  tbfl_pkg::res_t                out_res_r;
  logic                          s2_load;
  logic                          in_acc;
  logic signed [7:0]             temp_a, temp_b;
  tbfl_pkg::res_t                res;
  tbfl_pkg::cfg_t                cfg_r, cfg_nxt;
  logic [tbfl_pkg::BAND_W-1:0]   cur_level;

  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s2_load);
  assign out_valid_nxt = s2_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_a_r <= in_tdata[15:0];
      s1_b_r <= in_tdata[31:16];
    end
    if (s2_load) begin
      out_res_r <= res;
    end
  end

  tbfl_conv #(.SENSOR_BITS(SENSOR_BITS)) u_conv_a (.raw(s1_a_r), .deg(temp_a));
  tbfl_conv #(.SENSOR_BITS(SENSOR_BITS)) u_conv_b (.raw(s1_b_r), .deg(temp_b));

  tbfl_qual u_qual (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s2_load),
    .temp_a    (temp_a),
    .temp_b    (temp_b),
    .cfg       (cfg_r),
    .res       (res),
    .cur_level (cur_level)
  );

  // config registers; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        tbfl_pkg::REG_BAND0_LIMIT:   cfg_nxt.limit[0] = cfg_wdata;
        tbfl_pkg::REG_BAND1_LIMIT:   cfg_nxt.limit[1] = cfg_wdata;
        tbfl_pkg::REG_BAND2_LIMIT:   cfg_nxt.limit[2] = cfg_wdata;
        tbfl_pkg::REG_BAND3_LIMIT:   cfg_nxt.limit[3] = cfg_wdata;
        tbfl_pkg::REG_BAND4_LIMIT:   cfg_nxt.limit[4] = cfg_wdata;
        tbfl_pkg::REG_QUALIFY_COUNT: cfg_nxt.qual_cnt = cfg_wdata;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit[0] <= tbfl_pkg::BAND0_LIMIT_RST;
      cfg_r.limit[1] <= tbfl_pkg::BAND1_LIMIT_RST;
      cfg_r.limit[2] <= tbfl_pkg::BAND2_LIMIT_RST;
      cfg_r.limit[3] <= tbfl_pkg::BAND3_LIMIT_RST;
      cfg_r.limit[4] <= tbfl_pkg::BAND4_LIMIT_RST;
      cfg_r.qual_cnt <= tbfl_pkg::QUALIFY_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.sample_band, out_res_r.avg_temp,
                       out_res_r.fan_level};

  // a held input word must not be dropped while the result side is stalled
  `TBFL_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !s2_load, s1_valid_r,
    "input word lost while stalled")
  // qualified level moves only when a word passes to the result register
  `TBFL_ASSERT_NEXT(a_level_stable, clk, rst_n, !s2_load, $stable(cur_level),
    "fan level changed without a word")
  // the shown fan level is the one the qualifier now holds
  `TBFL_ASSERT_NEXT(a_level_match, clk, rst_n, s2_load,
    out_res_r.fan_level == cur_level, "result level differs from held level")
  `TBFL_ASSERT_NOW(a_band_range, clk, rst_n, out_valid_r,
    out_res_r.sample_band <= tbfl_pkg::BAND_TOP &&
    out_res_r.fan_level <= tbfl_pkg::BAND_TOP, "band out of range")

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for temp_band_fan_level_qualifier_core: stream driver, result checker
// and an in-bench model of conversion, averaging, banding and level qualification.
// Depends on tbfl_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;
  // indexes past the last register, writes there must be dropped
  localparam logic [tbfl_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [tbfl_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [15:0] b;
    logic [15:0] a;
  } sensor_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [tbfl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_cnt = 0;
  int fail_cnt = 0;

  sensor_word_t sensor_words[$];
  sensor_word_t offered;
  tbfl_pkg::res_t expected_levels[$];

  // model copy of config and qualifier state
  logic signed [7:0] band_limit[tbfl_pkg::NUM_LIMITS];
  logic [7:0] qualify_count;
  logic [2:0] last_band;
  logic [7:0] run_count;
  logic [2:0] fan_level_q;

  temp_band_fan_level_qualifier_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int sensor_degrees(logic [15:0] code);
    int d;
    d = (int'(code) * tbfl_pkg::TEMP_MUL) / (1 << tbfl_pkg::TEMP_SHIFT) - tbfl_pkg::TEMP_OFFSET;
    if (d > 127) d = 127;
    if (d < -128) d = -128;
    return d;
  endfunction

  // smallest code that reads as t degrees, plus an offset within the same degree
  function automatic logic [15:0] code_for_temp(int t, int extra);
    int c;
    if (t < -273) t = -273;
    if (t > 2700) t = 2700;
    c = ((t + 273) * (1 << tbfl_pkg::TEMP_SHIFT) + tbfl_pkg::TEMP_MUL - 1) / tbfl_pkg::TEMP_MUL;
    c = c + extra;
    if (c > 65535) c = 65535;
    return c[15:0];
  endfunction

  task automatic qualify_sample(sensor_word_t w);
    int ta, tb, avg, need;
    logic [2:0] band;
    tbfl_pkg::res_t r;
    ta = sensor_degrees(w.a);
    tb = sensor_degrees(w.b);
    avg = (ta + tb) / 2;
    band = tbfl_pkg::BAND_TOP;
    for (int k = tbfl_pkg::NUM_LIMITS - 1; k >= 0; k--)
      if (avg <= int'(band_limit[k])) band = 3'(k);
    need = (qualify_count == 8'd0) ? 1 : int'(qualify_count);
    if (band == last_band) run_count = run_count + 8'd1;
    else run_count = 8'd1;
    last_band = band;
    if (int'(run_count) == need) begin
      fan_level_q = band;
      run_count = '0;
    end
    r.fan_level = fan_level_q;
    r.avg_temp = avg[7:0];
    r.sample_band = band;
    expected_levels.push_back(r);
  endtask

  task automatic check_result(logic [15:0] d);
    tbfl_pkg::res_t e;
    if (expected_levels.size() == 0) begin
      $display("%0t: unexpected word 0x%04h", $time, d);
      fail_cnt++;
    end else begin
      e = expected_levels.pop_front();
      if (d[2:0] !== e.fan_level) begin
        $display("%0t: fan_level expected %0d actual %0d", $time, e.fan_level, d[2:0]);
        fail_cnt++;
      end
      if (d[10:3] !== e.avg_temp) begin
        $display("%0t: avg_temp expected %0d actual %0d", $time, e.avg_temp,
                 $signed(d[10:3]));
        fail_cnt++;
      end
      if (d[13:11] !== e.sample_band) begin
        $display("%0t: sample_band expected %0d actual %0d", $time, e.sample_band,
                 d[13:11]);
        fail_cnt++;
      end
    end
  endtask

  // driver: one word in flight on in_*, refilled from the queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) qualify_sample(offered);
      if (!in_tvalid || in_tready) begin
        if (sensor_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = sensor_words.pop_front();
          in_tdata <= offered;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (hold_cycles != 0) out_tready <= 1'b0;
      else out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("temp_band_fan_level_qualifier_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [tbfl_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < tbfl_pkg::NUM_LIMITS) band_limit[idx] = val;
    else if (idx == tbfl_pkg::REG_QUALIFY_COUNT) qualify_count = val;
  endtask

  task automatic close_cfg();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_ascending(logic [7:0] qc);
    int v;
    v = int'($urandom_range(0, 60)) - 30;
    for (int k = 0; k < tbfl_pkg::NUM_LIMITS; k++) begin
      write_reg(tbfl_pkg::REG_BAND0_LIMIT + 3'(k), 8'(v));
      v = v + int'($urandom_range(0, 6));
    end
    write_reg(tbfl_pkg::REG_QUALIFY_COUNT, qc);
    close_cfg();
  endtask

  task automatic write_all_limits(logic [7:0] lim, logic [7:0] qc);
    for (int k = 0; k < tbfl_pkg::NUM_LIMITS; k++)
      write_reg(tbfl_pkg::REG_BAND0_LIMIT + 3'(k), lim);
    write_reg(tbfl_pkg::REG_QUALIFY_COUNT, qc);
    close_cfg();
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (sensor_words.size() != 0 || in_tvalid || expected_levels.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic start_phase(int s, int r);
    @(negedge clk);
    send_idle_pct <= s;
    recv_stall_pct <= r;
  endtask

  task automatic push_raw(logic [15:0] a, logic [15:0] b);
    sensor_word_t w;
    w.a = a;
    w.b = b;
    sensor_words.push_back(w);
  endtask

  task automatic push_temps(int ta, int tb, int n);
    repeat (n) push_raw(code_for_temp(ta, $urandom_range(0, 20)),
                        code_for_temp(tb, $urandom_range(0, 20)));
  endtask

  // runs of samples around the thresholds, with some noise and rail codes
  task automatic push_mixed(int n);
    int t, len, need, sel, ja, jb;
    sensor_word_t w;
    need = (qualify_count == 8'd0) ? 1 : ((qualify_count > 8'd8) ? 8 : int'(qualify_count));
    while (n > 0) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) t = int'(band_limit[$urandom_range(0, 4)]) + int'($urandom_range(0, 2)) - 1;
      else if (sel < 90) t = int'($urandom_range(0, 300)) - 150;
      else t = int'($urandom_range(0, 3000)) - 300;
      len = $urandom_range(1, need + 2);
      repeat (len) begin
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
          ja = int'($urandom_range(0, 2)) - 1;
          jb = int'($urandom_range(0, 2)) - 1;
          w.a = code_for_temp(t + ja, $urandom_range(0, 20));
          w.b = code_for_temp(t + jb, $urandom_range(0, 20));
        end else if (sel < 95) begin
          w.a = 16'($urandom);
          w.b = 16'($urandom);
        end else begin
          w.a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          w.b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        sensor_words.push_back(w);
        n--;
      end
    end
  endtask

  initial begin
    band_limit[0] = tbfl_pkg::BAND0_LIMIT_RST;
    band_limit[1] = tbfl_pkg::BAND1_LIMIT_RST;
    band_limit[2] = tbfl_pkg::BAND2_LIMIT_RST;
    band_limit[3] = tbfl_pkg::BAND3_LIMIT_RST;
    band_limit[4] = tbfl_pkg::BAND4_LIMIT_RST;
    qualify_count = tbfl_pkg::QUALIFY_COUNT_RST;
    last_band = '0;
    run_count = '0;
    fan_level_q = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: rails, truncation of odd negative sums, each threshold edge
    start_phase(0, 0);
    push_raw(16'h0000, 16'h0000);
    push_raw(16'hFFFF, 16'hFFFF);
    push_raw(16'h0000, 16'hFFFF);
    push_raw(16'hFFFF, 16'h0000);
    push_temps(-3, 0, 1);
    push_temps(-128, -127, 1);
    push_temps(38, 38, 3);
    push_temps(39, 39, 3);
    push_temps(46, 46, 1);
    push_temps(47, 47, 1);
    push_temps(48, 48, 1);
    push_temps(49, 49, 3);
    push_temps(45, 46, 2);
    push_raw(16'h5555, 16'hAAAA);
    push_raw(16'hAAAA, 16'h5555);
    wait_idle();

    // reset config, long receiver hold-off so the input backs up
    start_phase(0, 0);
    push_mixed(60);
    hold_cycles <= 80;
    wait_idle();

    write_ascending(8'd1);
    start_phase(76, 0);
    push_mixed(60);
    wait_idle();

    // unordered limits, qualify count zero, writes to unused indexes
    for (int k = 0; k < tbfl_pkg::NUM_LIMITS; k++)
      write_reg(tbfl_pkg::REG_BAND0_LIMIT + 3'(k), 8'($urandom));
    write_reg(tbfl_pkg::REG_QUALIFY_COUNT, 8'd0);
    write_reg(REG_SPARE_6, 8'($urandom));
    write_reg(REG_SPARE_7, 8'($urandom));
    close_cfg();
    start_phase(0, 76);
    push_mixed(60);
    wait_idle();

    write_all_limits(8'h80, 8'd2);
    start_phase(17, 17);
    push_mixed(40);
    wait_idle();

    write_all_limits(8'h7F, 8'd4);
    start_phase(0, 76);
    push_mixed(30);
    wait_idle();

    // longest qualify count: one band held long enough to qualify
    write_reg(tbfl_pkg::REG_BAND0_LIMIT, 8'hEC);
    write_reg(tbfl_pkg::REG_BAND1_LIMIT, 8'h00);
    write_reg(tbfl_pkg::REG_BAND2_LIMIT, 8'h14);
    write_reg(tbfl_pkg::REG_BAND3_LIMIT, 8'h28);
    write_reg(tbfl_pkg::REG_BAND4_LIMIT, 8'h3C);
    write_reg(tbfl_pkg::REG_QUALIFY_COUNT, 8'd255);
    close_cfg();
    start_phase(17, 17);
    push_temps(10, 10, 10);
    push_temps(30, 30, 260);
    push_mixed(10);
    wait_idle();

    write_ascending(8'($urandom_range(1, 8)));
    start_phase(76, 0);
    push_mixed(60);
    wait_idle();

    if (fail_cnt == 0) begin
      $display("temp_band_fan_level_qualifier_core verification clean");
    end else begin
      $display("temp_band_fan_level_qualifier_core verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tbfl_pkg.sv
rtl/tbfl_conv.sv
rtl/tbfl_qual.sv
rtl/temp_band_fan_level_qualifier_core.sv
tb/sv/tb_top.sv
